[sv/lru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU recency list package
// Shared sizes, command and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAMES = 16;
    localparam int SLOT_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int PAGE_W = 20;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_EVICT = 2'd1,
        CMD_TOUCH = 2'd2,
        CMD_NOP   = 2'd3
    } lru_op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_UNUSED = 2'd3
    } lru_status_t;

    typedef struct packed {
        lru_op_t             cmd;
        logic [PAGE_W-1:0]   page_number;
        logic [3:0]          slot_index;
    } lru_req_t;

    typedef struct packed {
        logic [3:0]          slot_out;
        logic [PAGE_W-1:0]   page_out;
        lru_status_t         status;
        logic [4:0]          occupied;
    } lru_rsp_t;

endpackage

[sv/lru_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU input register
// Holds one command transaction until the core consumes it.
// ----------------------------------------------------------------------------
module lru_in_reg
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lru_req_t req,
    input  logic     take,
    output logic     hold_valid,
    output lru_req_t hold
);

    logic     valid_reg;
    logic     valid_next;
    lru_req_t data_reg;
    logic     accept;

    assign req_ready  = !valid_reg || take;
    assign accept     = req_valid && req_ready;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= req;
        end
    end

    assign hold_valid = valid_reg;
    assign hold       = data_reg;

endmodule

[sv/lru_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU recency core
// Recency order, slot pages and occupancy; one command per fire.
// ----------------------------------------------------------------------------
module lru_core
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  lru_req_t item,
    output lru_rsp_t result
);

    logic [SLOT_W-1:0] order_reg  [FRAMES];
    logic [SLOT_W-1:0] order_next [FRAMES];
    logic [PAGE_W-1:0] page_reg   [FRAMES];
    logic [FRAMES-1:0] used_reg;
    logic [FRAMES-1:0] used_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [SLOT_W-1:0] req_idx;
    logic              req_in_range;
    logic [SLOT_W-1:0] rd_idx;
    logic [PAGE_W-1:0] rd_page;
    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] at_or_after;
    logic [SLOT_W-1:0] slot;
    logic              page_we;
    lru_status_t       status;
    logic [PAGE_W-1:0] page_res;

    assign req_idx      = SLOT_W'(item.slot_index);
    assign req_in_range = int'(item.slot_index) < FRAMES;

    // single page read port: oldest slot on evict, requested slot otherwise
    assign rd_idx  = (item.cmd == CMD_EVICT) ? order_reg[0] : req_idx;
    assign rd_page = page_reg[rd_idx];

    // position of the touched slot among the occupied positions
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            match[i] = (order_reg[i] == req_idx) && (CNT_W'(i) < count_reg);
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            at_or_after[i] = 1'b0;
            for (int j = 0; j <= i; j++)
            begin
                at_or_after[i] = at_or_after[i] | match[j];
            end
        end
    end

    always_comb
    begin
        order_next = order_reg;
        used_next  = used_reg;
        count_next = count_reg;
        page_we    = 1'b0;
        slot       = '0;
        status     = ST_OK;
        page_res   = '0;
        case (item.cmd)
            CMD_PUSH:
            begin
                if (count_reg >= CNT_W'(FRAMES))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    slot            = order_reg[count_reg[SLOT_W-1:0]];
                    used_next[slot] = 1'b1;
                    count_next      = count_reg + 1'b1;
                    page_we         = 1'b1;
                end
            end
            CMD_EVICT:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    slot            = order_reg[0];
                    page_res        = rd_page;
                    used_next[slot] = 1'b0;
                    count_next      = count_reg - 1'b1;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        order_next[i] = order_reg[(i + 1) % FRAMES];
                    end
                end
            end
            CMD_TOUCH:
            begin
                slot = req_idx;
                if (!req_in_range || !used_reg[req_idx])
                begin
                    status = ST_UNUSED;
                end
                else
                begin
                    page_res = rd_page;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        if (at_or_after[i] && (CNT_W'(i + 1) < count_reg))
                        begin
                            order_next[i] = order_reg[(i + 1) % FRAMES];
                        end
                        else if (at_or_after[i] && (CNT_W'(i + 1) == count_reg))
                        begin
                            order_next[i] = req_idx;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.slot_out = (item.cmd == CMD_TOUCH) ? item.slot_index : 4'(slot);
        result.page_out = page_res;
        result.status   = status;
        result.occupied = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                order_reg[i] <= SLOT_W'(i);
            end
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            order_reg <= order_next;
            used_reg  <= used_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && page_we)
        begin
            page_reg[slot] <= item.page_number;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRAMES))
        else $error("occupancy beyond frame count");

    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(count_reg))
        else $error("used flags disagree with occupancy");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.cmd == CMD_PUSH && status == ST_OK
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("successful push did not grow occupancy");

    a_oldest_used: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> used_reg[order_reg[0]])
        else $error("oldest position holds a free slot");
`endif

endmodule

[sv/lru_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module lru_out_reg
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  lru_rsp_t result,
    output logic     can_load,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lru_rsp_t rsp
);

    logic     valid_reg;
    logic     valid_next;
    lru_rsp_t data_reg;

    assign can_load   = !valid_reg || rsp_ready;
    assign valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

[sv/lru_recency_order_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU recency order list
// Keeps page numbers in least-recently-used order over the frame slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | cmd, page_number, slot_index
//  rsp     | out       | rsp_valid / rsp_ready | slot_out, page_out, status, occ.
//
// One command transaction per cycle sustained while rsp_ready holds high; each
// gives exactly one result. A command passes the input register, then the recency
// update (parallel compare and shift over all positions) into the result reg.
// Reset puts slots 0..FRAMES-1 in order, all free; no clearing pass is run.
// A stalled result holds the core; the input register still takes one more
// command, and req_ready falls only when both registers are full.
//
module lru_recency_order_list
    import lru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lru_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lru_rsp_t rsp
);

    logic     hold_valid;
    lru_req_t hold;
    logic     can_load;
    logic     fire;
    lru_rsp_t result;

    // the core runs a command only when its result has somewhere to go
    assign fire = hold_valid && can_load;

    lru_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .take       (fire),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    lru_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (hold),
        .result (result)
    );

    lru_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .can_load  (can_load),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    a_occupied_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupied <= 5'(FRAMES))
        else $error("reported occupancy beyond frame count");

    a_push_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.page_out == '0)
        else $error("failed command returned a page");
`endif

endmodule
